// ----- sv/glyph_quad_text_layout_defines.svh -----
// Assertion macros shared by the glyph quad text layout RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GQTL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GQTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gqtl_pkg.sv -----
// Shared types, codes and arithmetic helpers for the glyph quad text layout.
// No dependencies; used by every module of the block except gqtl_ram.
package gqtl_pkg;

    localparam int GLYPH_COUNT_DEF = 128;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    localparam logic [1:0] CFG_CHAR_HEIGHT  = 2'd0;
    localparam logic [1:0] CFG_LINE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd3;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    localparam logic signed [31:0] POS_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;
    localparam logic [15:0] LINE_MAX = 16'hffff;
    localparam logic [23:0] VERT_MAX = 24'hffffff;

    typedef enum logic [2:0] {
        K_LOAD, K_START, K_NEWLINE, K_SPACE, K_DRAW, K_STATUS
    } t_kind;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         code;
        logic signed [31:0] plane_left;
        logic signed [31:0] plane_right;
        logic signed [31:0] plane_top;
        logic signed [31:0] plane_bottom;
        logic [31:0]        atlas_left;
        logic [31:0]        atlas_top;
        logic [31:0]        atlas_right;
        logic [31:0]        atlas_bottom;
        logic signed [31:0] advance;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic [31:0]        tex_u;
        logic [31:0]        tex_v;
        logic               has_vertex;
        logic               last;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic [15:0]        line_total;
        logic [23:0]        vertex_total;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] pl;
        logic signed [31:0] pr;
        logic signed [31:0] pt;
        logic signed [31:0] pb;
        logic [31:0]        al;
        logic [31:0]        at;
        logic [31:0]        ar;
        logic [31:0]        ab;
        logic signed [31:0] adv;
    } t_glyph;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        t_glyph     glyph;
    } t_q_ent;

    typedef struct packed {
        logic [30:0] char_height;
        logic [30:0] line_height;
        logic [15:0] atlas_width;
        logic [15:0] atlas_height;
    } t_cfg;

    // Product >> 16 rounded toward minus infinity, saturated to 32 bits.
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [47:0] q;
        q = p[63:16];
        if (q > 48'sh00007fffffff)      qscale = POS_MAX;
        else if (q < -48'sh000080000000) qscale = POS_MIN;
        else                             qscale = q[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        if (s[32] != s[31]) sat33 = s[32] ? POS_MIN : POS_MAX;
        else                sat33 = s[31:0];
    endfunction

endpackage

// ----- sv/glyph_quad_text_layout.sv -----
// Glyph quad text layout, top level: configuration registers, front and back.
// Depends on gqtl_pkg, gqtl_front, gqtl_back (and gqtl_ram below it).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in_data) takes one
//   command beat: load glyph, start text, or lay out a character. A beat is
//   taken when valid is high and stall is low.
//   Output channel (o_out_valid / i_out_stall, payload o_out_data) returns
//   six vertex beats for a drawn character, else one status beat; last marks
//   the final beat of each command.
//   Configuration port (i_cfg_valid / o_cfg_ready, index and data) writes
//   char height, line height, atlas width and height; write only when idle.
// Sequence:
//   A two-entry command queue parts the front from the back, so input beats
//   keep landing while the back works or the receiver stalls.
//   Drawn character: table read, multiplier pass, update, bounds, then the
//   shared divider, which makes the four texture quotients at two bits a
//   cycle, and last six output beats. Newline: multiplier pass and update;
//   space adds a table read before them. Load, start and skipped codes go
//   straight to their status beat.
// Reset: synchronous, active low; clears the pen, bounds and counters, the
//   queue and the output valid flag, and loads register defaults. The glyph
//   table holds no defined contents until loaded.
// Stall: a held output beat keeps its payload; the back waits before the
//   next beat and the queue fills, then o_in_stall rises.
module glyph_quad_text_layout #(
    parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gqtl_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gqtl_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    gqtl_pkg::t_cfg   r_cfg;
    logic             q_valid, pop;
    gqtl_pkg::t_q_ent q_ent;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_height  <= 31'd65536;
            r_cfg.line_height  <= 31'd65536;
            r_cfg.atlas_width  <= 16'd512;
            r_cfg.atlas_height <= 16'd512;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gqtl_pkg::CFG_CHAR_HEIGHT:  r_cfg.char_height  <= i_cfg_data[30:0];
                gqtl_pkg::CFG_LINE_HEIGHT:  r_cfg.line_height  <= i_cfg_data[30:0];
                gqtl_pkg::CFG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_data[15:0];
                gqtl_pkg::CFG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Classify and queue input beats.
    gqtl_front #(.GLYPH_COUNT(GLYPH_COUNT)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data (i_in_data),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_q_ent   (q_ent)
    );

    // Execute queued commands and drive the output register.
    gqtl_back #(.GLYPH_COUNT(GLYPH_COUNT)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_ent    (q_ent),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );
endmodule

// ----- sv/gqtl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gqtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/gqtl_front.sv -----
// Front end: accepts input beats, classifies them and queues them.
// Depends on gqtl_pkg.
module gqtl_front #(
    parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gqtl_pkg::t_in_item i_in_data,
    input  logic              i_pop,
    output logic              o_q_valid,
    output gqtl_pkg::t_q_ent  o_q_ent
);
    localparam int QD  = gqtl_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);

    gqtl_pkg::t_q_ent r_ent [QD];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    gqtl_pkg::t_q_ent cls;
    logic             push, in_range;

    always_comb begin
        in_range = {1'b0, i_in_data.code} < 9'(GLYPH_COUNT);
        cls.code = i_in_data.code;
        cls.glyph.pl  = i_in_data.plane_left;
        cls.glyph.pr  = i_in_data.plane_right;
        cls.glyph.pt  = i_in_data.plane_top;
        cls.glyph.pb  = i_in_data.plane_bottom;
        cls.glyph.al  = i_in_data.atlas_left;
        cls.glyph.at  = i_in_data.atlas_top;
        cls.glyph.ar  = i_in_data.atlas_right;
        cls.glyph.ab  = i_in_data.atlas_bottom;
        cls.glyph.adv = i_in_data.advance;
        unique case (i_in_data.cmd)
            gqtl_pkg::CMD_LOAD:  cls.kind = in_range ? gqtl_pkg::K_LOAD : gqtl_pkg::K_STATUS;
            gqtl_pkg::CMD_START: cls.kind = gqtl_pkg::K_START;
            gqtl_pkg::CMD_CHAR: begin
                if (i_in_data.code == gqtl_pkg::CODE_NEWLINE)
                    cls.kind = gqtl_pkg::K_NEWLINE;
                else if (!in_range || i_in_data.code == gqtl_pkg::CODE_RETURN)
                    cls.kind = gqtl_pkg::K_STATUS;
                else if (i_in_data.code == gqtl_pkg::CODE_SPACE)
                    cls.kind = gqtl_pkg::K_SPACE;
                else
                    cls.kind = gqtl_pkg::K_DRAW;
            end
            default: cls.kind = gqtl_pkg::K_STATUS;
        endcase
    end

    assign o_in_stall = (r_cnt == (QAW+1)'(QD));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_ent    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QAW'(QD-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QD-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_pop);
        end
        if (push) begin
            r_ent[r_wp] <= cls;
        end
    end
endmodule

// ----- sv/gqtl_back.sv -----
// Back end: runs queued commands, owns the glyph table and the output register.
// Depends on gqtl_pkg, gqtl_ram and the assertion macro header.
`include "glyph_quad_text_layout_defines.svh"
module gqtl_back #(
    parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gqtl_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  gqtl_pkg::t_q_ent   i_q_ent,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gqtl_pkg::t_out_item o_out_data
);
    localparam int AW = $clog2(GLYPH_COUNT);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_UPD  = 7'b0001000,
        S_BND  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state              r_state;
    gqtl_pkg::t_kind     r_kind;
    gqtl_pkg::t_glyph    r_g, rd_g;
    logic [2:0]          r_mstep, r_k;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_sc [5];
    logic signed [31:0]  r_cx, r_cy, r_ax, r_ay, r_bx, r_by;
    logic signed [31:0]  r_minx, r_miny, r_maxx, r_maxy;
    logic [15:0]         r_lcnt;
    logic [23:0]         r_vcnt;
    logic [1:0]          r_dsel;
    logic [3:0]          r_dcnt;
    logic [16:0]         r_rem;
    logic [31:0]         r_quo;
    logic [31:0]         r_u0, r_u1, r_v0, r_v1;
    logic                r_oval;
    gqtl_pkg::t_out_item r_out;

    logic                ram_we;
    logic signed [31:0]  mul_a;
    logic [15:0]         dv;
    logic [16:0]         t1, t2;
    logic [31:0]         q1, q2;
    logic                can_load;
    logic [23:0]         vcnt_inc;
    gqtl_pkg::t_out_item vtx;

    assign o_pop  = (r_state == S_IDLE) && i_q_valid;
    assign ram_we = o_pop && (i_q_ent.kind == gqtl_pkg::K_LOAD);

    gqtl_ram #(.WIDTH($bits(gqtl_pkg::t_glyph)), .DEPTH(GLYPH_COUNT)) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_q_ent.code[AW-1:0]),
        .i_wdata(i_q_ent.glyph),
        .i_re   (o_pop),
        .i_raddr(i_q_ent.code[AW-1:0]),
        .o_rdata(rd_g)
    );

    // Multiplier operand: one metric per step, or the line pitch on newline.
    always_comb begin
        case (r_mstep)
            3'd0:    mul_a = r_g.pl;
            3'd1:    mul_a = r_g.pr;
            3'd2:    mul_a = r_g.pt;
            3'd3:    mul_a = r_g.pb;
            default: mul_a = r_g.adv;
        endcase
        if (r_kind == gqtl_pkg::K_NEWLINE) mul_a = {1'b0, i_cfg.line_height};
    end

    // Two restoring divide steps per cycle; zero divisor divides as one.
    always_comb begin
        dv = (r_dsel < 2'd2) ? i_cfg.atlas_width : i_cfg.atlas_height;
        if (dv == '0) dv = 16'd1;
        t1 = {r_rem[15:0], r_quo[31]};
        q1 = {r_quo[30:0], 1'b0};
        if (t1 >= {1'b0, dv}) begin
            t1 = t1 - {1'b0, dv};
            q1[0] = 1'b1;
        end
        t2 = {t1[15:0], q1[31]};
        q2 = {q1[30:0], 1'b0};
        if (t2 >= {1'b0, dv}) begin
            t2 = t2 - {1'b0, dv};
            q2[0] = 1'b1;
        end
    end

    // Corner selection: order is (a,a) (b,a) (b,b) (a,b) (a,a) (b,b).
    always_comb begin
        vcnt_inc = (r_vcnt == gqtl_pkg::VERT_MAX) ? r_vcnt : r_vcnt + 24'd1;
        vtx.has_vertex   = 1'b1;
        vtx.last         = (r_k == 3'd5);
        vtx.min_x        = r_minx;
        vtx.min_y        = r_miny;
        vtx.max_x        = r_maxx;
        vtx.max_y        = r_maxy;
        vtx.line_total   = r_lcnt;
        vtx.vertex_total = vcnt_inc;
        case (r_k)
            3'd0, 3'd4: begin
                vtx.vert_x = r_ax; vtx.tex_u = r_u0; vtx.vert_y = r_ay; vtx.tex_v = r_v0;
            end
            3'd1: begin
                vtx.vert_x = r_bx; vtx.tex_u = r_u1; vtx.vert_y = r_ay; vtx.tex_v = r_v0;
            end
            3'd3: begin
                vtx.vert_x = r_ax; vtx.tex_u = r_u0; vtx.vert_y = r_by; vtx.tex_v = r_v1;
            end
            default: begin
                vtx.vert_x = r_bx; vtx.tex_u = r_u1; vtx.vert_y = r_by; vtx.tex_v = r_v1;
            end
        endcase
    end

    assign can_load = !r_oval || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, i_cfg.char_height});
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_mstep <= '0;
            r_k     <= '0;
            r_dsel  <= '0;
            r_dcnt  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_minx  <= gqtl_pkg::POS_MAX;
            r_miny  <= gqtl_pkg::POS_MAX;
            r_maxx  <= gqtl_pkg::POS_MIN;
            r_maxy  <= gqtl_pkg::POS_MIN;
            r_lcnt  <= 16'd1;
            r_vcnt  <= '0;
        end else begin
            // Drop the beat once taken; the emit state reloads it itself.
            if (r_oval && !i_out_stall && r_state != S_EMIT) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kind  <= i_q_ent.kind;
                        r_mstep <= '0;
                        unique case (i_q_ent.kind)
                            gqtl_pkg::K_START: begin
                                r_cx   <= '0;
                                r_cy   <= '0;
                                r_minx <= gqtl_pkg::POS_MAX;
                                r_miny <= gqtl_pkg::POS_MAX;
                                r_maxx <= gqtl_pkg::POS_MIN;
                                r_maxy <= gqtl_pkg::POS_MIN;
                                r_lcnt <= 16'd1;
                                r_vcnt <= '0;
                                r_state <= S_EMIT;
                            end
                            gqtl_pkg::K_NEWLINE: r_state <= S_MUL;
                            gqtl_pkg::K_SPACE,
                            gqtl_pkg::K_DRAW:    r_state <= S_READ;
                            default:             r_state <= S_EMIT;
                        endcase
                    end
                end
                S_READ: begin
                    r_g     <= rd_g;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mstep != 3'd0) r_sc[r_mstep - 3'd1] <= gqtl_pkg::qscale(r_prod);
                    if (r_mstep == 3'd5) r_state <= S_UPD;
                    else                 r_mstep <= r_mstep + 3'd1;
                end
                S_UPD: begin
                    r_ax <= gqtl_pkg::sat33(33'(r_cx) + 33'(r_sc[0]));
                    r_bx <= gqtl_pkg::sat33(33'(r_cx) + 33'(r_sc[1]));
                    r_ay <= gqtl_pkg::sat33(33'(r_cy) - 33'(r_sc[2]));
                    r_by <= gqtl_pkg::sat33(33'(r_cy) - 33'(r_sc[3]));
                    if (r_kind == gqtl_pkg::K_NEWLINE) begin
                        r_cx <= '0;
                        r_cy <= gqtl_pkg::sat33(33'(r_cy) + 33'(r_sc[4]));
                        if (r_lcnt != gqtl_pkg::LINE_MAX) r_lcnt <= r_lcnt + 16'd1;
                        r_state <= S_EMIT;
                    end else begin
                        r_cx <= gqtl_pkg::sat33(33'(r_cx) + 33'(r_sc[4]));
                        r_state <= (r_kind == gqtl_pkg::K_DRAW) ? S_BND : S_EMIT;
                    end
                end
                S_BND: begin
                    if (r_ax < r_minx) r_minx <= r_ax;
                    if (r_ay < r_miny) r_miny <= r_ay;
                    if (r_bx > r_maxx) r_maxx <= r_bx;
                    if (r_by > r_maxy) r_maxy <= r_by;
                    r_dsel  <= '0;
                    r_dcnt  <= '0;
                    r_rem   <= '0;
                    r_quo   <= r_g.al;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_rem <= '0;
                        case (r_dsel)
                            2'd0:    begin r_u0 <= q2; r_quo <= r_g.ar; end
                            2'd1:    begin r_u1 <= q2; r_quo <= r_g.at; end
                            2'd2:    begin r_v0 <= q2; r_quo <= r_g.ab; end
                            default: begin r_v1 <= q2; r_quo <= q2; end
                        endcase
                        r_dsel <= r_dsel + 2'd1;
                        if (r_dsel == 2'd3) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_rem <= t2;
                        r_quo <= q2;
                    end
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_oval <= 1'b1;
                        if (r_kind == gqtl_pkg::K_DRAW) begin
                            r_out  <= vtx;
                            r_vcnt <= vcnt_inc;
                            r_k    <= r_k + 3'd1;
                            if (r_k == 3'd5) r_state <= S_IDLE;
                        end else begin
                            r_out.vert_x       <= '0;
                            r_out.vert_y       <= '0;
                            r_out.tex_u        <= '0;
                            r_out.tex_v        <= '0;
                            r_out.has_vertex   <= 1'b0;
                            r_out.last         <= 1'b1;
                            r_out.min_x        <= r_minx;
                            r_out.min_y        <= r_miny;
                            r_out.max_x        <= r_maxx;
                            r_out.max_y        <= r_maxy;
                            r_out.line_total   <= r_lcnt;
                            r_out.vertex_total <= r_vcnt;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    `GQTL_ASSERT_NOW(a_status_last, i_clk, i_rst_n, r_oval && !r_out.has_vertex, r_out.last, "status beat without last")
    `GQTL_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_pop, i_q_valid, "pop from empty queue")
    `GQTL_ASSERT_NOW(a_line_nonzero, i_clk, i_rst_n, 1'b1, r_lcnt != 16'd0, "line count reached zero")
    `GQTL_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, r_state == S_EMIT && can_load && r_out.last == 1'b0 && r_kind != gqtl_pkg::K_DRAW, r_state == S_IDLE, "status emit did not finish")
endmodule

// ----- verif/tb.sv -----
// Self-checking bench for glyph_quad_text_layout: drives command beats and
// register writes, predicts every output beat and compares the whole beat.
// Depends on gqtl_pkg and the glyph_quad_text_layout RTL.
`timescale 1ns / 100ps

module tb;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Layout predictor plus the queue of expected output beats.
    class layout_scoreboard;
        gqtl_pkg::t_cfg      cfg;
        gqtl_pkg::t_glyph    glyphs [128];
        logic signed [31:0] pen_x, pen_y, lo_x, lo_y, hi_x, hi_y;
        logic [15:0] lines;
        logic [23:0] verts;
        gqtl_pkg::t_out_item beats_due [$];
        int        mismatches;

        function void reset_all();
            cfg.char_height  = 31'd65536;
            cfg.line_height  = 31'd65536;
            cfg.atlas_width  = 16'd512;
            cfg.atlas_height = 16'd512;
            clear_text();
            mismatches = 0;
        endfunction

        function void clear_text();
            pen_x = 0; pen_y = 0;
            lo_x = gqtl_pkg::POS_MAX; lo_y = gqtl_pkg::POS_MAX;
            hi_x = gqtl_pkg::POS_MIN; hi_y = gqtl_pkg::POS_MIN;
            lines = 1; verts = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                gqtl_pkg::CFG_CHAR_HEIGHT:  cfg.char_height  = d[30:0];
                gqtl_pkg::CFG_LINE_HEIGHT:  cfg.line_height  = d[30:0];
                gqtl_pkg::CFG_ATLAS_WIDTH:  cfg.atlas_width  = d[15:0];
                default:                    cfg.atlas_height = d[15:0];
            endcase
        endfunction

        // Floor of p / 2^16, clamped to 32-bit signed.
        function logic signed [31:0] floor_q16(longint p);
            longint q;
            q = p >>> 16;
            if (q > 64'sd2147483647) return gqtl_pkg::POS_MAX;
            if (q < -64'sd2147483648) return gqtl_pkg::POS_MIN;
            return q[31:0];
        endfunction

        function logic signed [31:0] scaled(logic signed [31:0] m);
            longint h;
            h = longint'({1'b0, cfg.char_height});
            return floor_q16(longint'(m) * h);
        endfunction

        function logic signed [31:0] clamp_add(logic signed [31:0] a, longint b);
            longint s;
            s = longint'(a) + b;
            if (s > 64'sd2147483647) return gqtl_pkg::POS_MAX;
            if (s < -64'sd2147483648) return gqtl_pkg::POS_MIN;
            return s[31:0];
        endfunction

        function void push_beat(logic signed [31:0] x, logic signed [31:0] y,
                                logic [31:0] u, logic [31:0] v, bit hv, bit lst);
            gqtl_pkg::t_out_item o;
            o.vert_x = x; o.vert_y = y; o.tex_u = u; o.tex_v = v;
            o.has_vertex = hv; o.last = lst;
            o.min_x = lo_x; o.min_y = lo_y; o.max_x = hi_x; o.max_y = hi_y;
            o.line_total = lines; o.vertex_total = verts;
            beats_due.push_back(o);
        endfunction

        function void note_command(gqtl_pkg::t_in_item c);
            gqtl_pkg::t_glyph g;
            logic signed [31:0] ax, ay, bx, by;
            logic [31:0] w, h, u0, u1, v0, v1;
            logic signed [31:0] xs [6], ys [6];
            logic [31:0] us [6], vs [6];
            if (c.cmd == gqtl_pkg::CMD_LOAD) begin
                if (c.code < 128) begin
                    glyphs[c.code] = '{c.plane_left, c.plane_right, c.plane_top,
                        c.plane_bottom, c.atlas_left, c.atlas_top, c.atlas_right,
                        c.atlas_bottom, c.advance};
                end
            end else if (c.cmd == gqtl_pkg::CMD_START) begin
                clear_text();
            end else if (c.cmd == gqtl_pkg::CMD_CHAR) begin
                if (c.code == gqtl_pkg::CODE_NEWLINE) begin
                    pen_x = 0;
                    pen_y = clamp_add(pen_y, floor_q16(longint'({1'b0, cfg.char_height})
                        * longint'({1'b0, cfg.line_height})));
                    if (lines != gqtl_pkg::LINE_MAX) lines++;
                end else if (c.code >= 128 || c.code == gqtl_pkg::CODE_RETURN) begin
                end else if (c.code == gqtl_pkg::CODE_SPACE) begin
                    pen_x = clamp_add(pen_x, scaled(glyphs[c.code].adv));
                end else begin
                    g = glyphs[c.code];
                    w = cfg.atlas_width == 0 ? 1 : cfg.atlas_width;
                    h = cfg.atlas_height == 0 ? 1 : cfg.atlas_height;
                    ax = clamp_add(pen_x, scaled(g.pl));
                    ay = clamp_add(pen_y, -longint'(scaled(g.pt)));
                    bx = clamp_add(pen_x, scaled(g.pr));
                    by = clamp_add(pen_y, -longint'(scaled(g.pb)));
                    u0 = g.al / w; u1 = g.ar / w; v0 = g.at / h; v1 = g.ab / h;
                    if (ax < lo_x) lo_x = ax;
                    if (ay < lo_y) lo_y = ay;
                    if (bx > hi_x) hi_x = bx;
                    if (by > hi_y) hi_y = by;
                    pen_x = clamp_add(pen_x, scaled(g.adv));
                    xs = '{ax, bx, bx, ax, ax, bx}; ys = '{ay, ay, by, by, ay, by};
                    us = '{u0, u1, u1, u0, u0, u1}; vs = '{v0, v0, v1, v1, v0, v1};
                    for (int k = 0; k < 6; k++) begin
                        if (verts != gqtl_pkg::VERT_MAX) verts++;
                        push_beat(xs[k], ys[k], us[k], vs[k], 1'b1, k == 5);
                    end
                    return;
                end
            end
            push_beat(32'sd0, 32'sd0, 32'd0, 32'd0, 1'b0, 1'b1);
        endfunction

        function void check_beat(gqtl_pkg::t_out_item got);
            gqtl_pkg::t_out_item want;
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %p", got);
                return;
            end
            want = beats_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic      i_clk = 0, i_rst_n = 0;
    logic      i_in_valid = 0, i_out_stall = 0, i_cfg_valid = 0;
    gqtl_pkg::t_in_item  i_in_data = '0;
    logic [1:0]  i_cfg_index = gqtl_pkg::CFG_CHAR_HEIGHT;
    logic [31:0] i_cfg_data = '0;
    logic      o_in_stall, o_out_valid, o_cfg_ready;
    gqtl_pkg::t_out_item o_out_data;

    layout_scoreboard sb;
    bit  hold_off_req;   // asks the receiver for one long stall stretch
    bit  rx_bursty;      // lets the receiver draw random stall gaps

    glyph_quad_text_layout u_dut (.*);

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: check every taken beat; stall at random or for a long stretch.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) sb.check_beat(o_out_data);
            if (hold_off_req) begin
                i_out_stall <= 1;
                repeat (400) begin
                    @(posedge i_clk);
                end
                hold_off_req = 0;
                i_out_stall <= 0;
            end else if (o_out_valid && !i_out_stall && rx_bursty) begin
                gap = $urandom_range(0, 11);
                if (gap > 6) i_out_stall <= 1;
                else i_out_stall <= 0;
            end else begin
                i_out_stall <= rx_bursty && ($urandom_range(0, 11) > 8);
            end
        end
    end

    // Offer one command beat; hold it until taken; if gaps, idle a random gap.
    task automatic send_cmd(gqtl_pkg::t_in_item c, bit gaps);
        int gap;
        i_in_valid <= 1;
        i_in_data  <= c;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(c);
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic release_input();
        i_in_valid <= 0;
    endtask

    // Let all due beats drain, then wait out the back end before a write.
    task automatic drain();
        int guard;
        release_input();
        guard = 0;
        while (sb.beats_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    // Write one register, then drop valid so the next write is a new beat.
    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic gqtl_pkg::t_in_item glyph_load(logic [7:0] code, bit wild);
        gqtl_pkg::t_in_item c;
        c.cmd = gqtl_pkg::CMD_LOAD; c.code = code;
        if (wild) begin
            c.plane_left = $urandom; c.plane_right = $urandom;
            c.plane_top = $urandom; c.plane_bottom = $urandom;
            c.atlas_left = $urandom; c.atlas_top = $urandom;
            c.atlas_right = $urandom; c.atlas_bottom = $urandom;
            c.advance = $urandom;
        end else begin
            // Typical font metrics: magnitudes below 1.4 em, atlas edges below 1088 px.
            c.plane_left = $urandom_range(0, 8192) - 4096;
            c.plane_right = c.plane_left + $urandom_range(0, 65536);
            c.plane_top = $urandom_range(0, 65536);
            c.plane_bottom = c.plane_top - $urandom_range(0, 90000);
            c.atlas_left = $urandom_range(0, 32'h3ff_ffff);
            c.atlas_right = c.atlas_left + $urandom_range(0, 32'h3f_ffff);
            c.atlas_top = $urandom_range(0, 32'h3ff_ffff);
            c.atlas_bottom = c.atlas_top + $urandom_range(0, 32'h3f_ffff);
            c.advance = $urandom_range(0, 70000);
        end
        return c;
    endfunction

    function automatic gqtl_pkg::t_in_item text_cmd(logic [1:0] cmd, logic [7:0] code);
        gqtl_pkg::t_in_item c;
        c.plane_left = $urandom; c.plane_right = $urandom;
        c.plane_top = $urandom; c.plane_bottom = $urandom;
        c.atlas_left = $urandom; c.atlas_top = $urandom;
        c.atlas_right = $urandom; c.atlas_bottom = $urandom;
        c.advance = $urandom;
        c.cmd = cmd; c.code = code;
        return c;
    endfunction

    // Pick a character code: mostly drawable, with every special case mixed in.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return gqtl_pkg::CODE_NEWLINE;
        if (r == 1) return gqtl_pkg::CODE_SPACE;
        if (r == 2) return gqtl_pkg::CODE_RETURN;
        if (r == 3) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic random_phase(int items, bit wild_glyphs);
        int r;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_cmd(glyph_load(8'($urandom_range(0, 255)), wild_glyphs ||
                    $urandom_range(0, 3) == 0), 1);
            else if (r < 12) send_cmd(text_cmd(gqtl_pkg::CMD_START, 8'($urandom)), 1);
            else if (r < 14) send_cmd(text_cmd(CMD_UNUSED, 8'($urandom)), 1);
            else send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, pick_char()), rx_bursty);
        end
    endtask

    initial begin
        gqtl_pkg::t_in_item c;
        sb = new();
        sb.reset_all();
        hold_off_req = 0;
        rx_bursty = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Fill the whole table so no character reads an unwritten entry.
        for (int g = 0; g < 128; g++) send_cmd(glyph_load(8'(g), 0), 0);

        // Directed: extreme metrics, every command, newline, space, return,
        // out-of-range load and character, and the unused command.
        c = glyph_load(8'd65, 1);
        c.plane_left = gqtl_pkg::POS_MIN; c.plane_right = gqtl_pkg::POS_MAX;
        c.plane_top = gqtl_pkg::POS_MAX; c.plane_bottom = gqtl_pkg::POS_MIN;
        c.atlas_left = 0; c.atlas_right = '1; c.atlas_top = '1; c.atlas_bottom = 0;
        c.advance = gqtl_pkg::POS_MAX;
        send_cmd(c, 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_START, 8'd0), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd65), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd65), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_NEWLINE), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_SPACE), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_RETURN), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd255), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd128), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd0), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd127), 0);
        send_cmd(glyph_load(8'd200, 1), 0);
        send_cmd(text_cmd(CMD_UNUSED, 8'hff), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_START, 8'hff), 0);
        drain();

        // Extreme registers: zero sizes divide as one, top scales saturate.
        write_reg(gqtl_pkg::CFG_CHAR_HEIGHT, 32'hffff_ffff);
        write_reg(gqtl_pkg::CFG_LINE_HEIGHT, 32'h7fff_ffff);
        write_reg(gqtl_pkg::CFG_ATLAS_WIDTH, 32'h0000_0000);
        write_reg(gqtl_pkg::CFG_ATLAS_HEIGHT, 32'hffff_ffff);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd65), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_NEWLINE), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_SPACE), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd66), 0);
        drain();

        write_reg(gqtl_pkg::CFG_CHAR_HEIGHT, 32'h0);
        write_reg(gqtl_pkg::CFG_LINE_HEIGHT, 32'h0);
        write_reg(gqtl_pkg::CFG_ATLAS_WIDTH, 32'd1);
        write_reg(gqtl_pkg::CFG_ATLAS_HEIGHT, 32'h0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, 8'd66), 0);
        send_cmd(text_cmd(gqtl_pkg::CMD_CHAR, gqtl_pkg::CODE_NEWLINE), 0);
        drain();

        // Random phases across several register settings.
        rx_bursty = 1;
        write_reg(gqtl_pkg::CFG_CHAR_HEIGHT, 32'd65536);
        write_reg(gqtl_pkg::CFG_LINE_HEIGHT, 32'd78000);
        write_reg(gqtl_pkg::CFG_ATLAS_WIDTH, 32'd512);
        write_reg(gqtl_pkg::CFG_ATLAS_HEIGHT, 32'd512);
        random_phase(110, 0);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off_req = 1;
        random_phase(30, 0);
        drain();

        write_reg(gqtl_pkg::CFG_CHAR_HEIGHT, $urandom_range(0, 32'h7fff_ffff));
        write_reg(gqtl_pkg::CFG_LINE_HEIGHT, $urandom_range(0, 32'h7fff_ffff));
        write_reg(gqtl_pkg::CFG_ATLAS_WIDTH, $urandom_range(1, 65535));
        write_reg(gqtl_pkg::CFG_ATLAS_HEIGHT, $urandom_range(1, 65535));
        random_phase(110, 1);
        drain();

        write_reg(gqtl_pkg::CFG_CHAR_HEIGHT, 32'd2048 << 16);
        write_reg(gqtl_pkg::CFG_LINE_HEIGHT, 32'd300000);
        write_reg(gqtl_pkg::CFG_ATLAS_WIDTH, 32'd65535);
        write_reg(gqtl_pkg::CFG_ATLAS_HEIGHT, 32'd3);
        random_phase(110, 0);
        drain();

        if (sb.mismatches == 0 && sb.beats_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
